// ===== design/spq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared sizes, operation and status codes, and the entry and command types
// used by the cell row and the top level.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Queue depth and field widths.
   localparam int CAPACITY      = 16;
   localparam int PRIORITY_BITS = 16;
   localparam int DATA_BITS     = 32;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);

   // Operation codes.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   // Status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_POP_EMPTY = 2'd2;

   // One stored entry.
   typedef struct packed {
      logic                            valid;
      logic signed [PRIORITY_BITS-1:0] prio;
      logic        [DATA_BITS-1:0]     data;
   } entry_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic                            ins;
      logic                            pop;
      logic signed [PRIORITY_BITS-1:0] prio;
      logic        [DATA_BITS-1:0]     data;
   } cmd_type;

endpackage
`default_nettype wire

// ===== design/spq_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface spq_req_if
   import spq_pkg::*;
   ();
   logic                            valid;
   logic                            ready;
   logic                            opcode;
   logic signed [PRIORITY_BITS-1:0] priority_req;
   logic        [DATA_BITS-1:0]     item_data;

   modport source (output valid, output opcode, output priority_req, output item_data,
                   input ready);
   modport sink   (input valid, input opcode, input priority_req, input item_data,
                   output ready);
endinterface

interface spq_rsp_if
   import spq_pkg::*;
   ();
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic                            popped_valid;
   logic        [DATA_BITS-1:0]     popped_data;
   logic        [DATA_BITS-1:0]     head_data;
   logic signed [PRIORITY_BITS-1:0] head_priority;
   logic                            is_empty;
   logic        [COUNT_BITS-1:0]    entry_count;

   modport source (output valid, output status, output popped_valid, output popped_data,
                   output head_data, output head_priority, output is_empty,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input popped_valid, input popped_data,
                   input head_data, input head_priority, input is_empty,
                   input entry_count, output ready);
endinterface
`default_nettype wire

// ===== design/spq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry of the sorted row. On insert it keeps its entry, takes the
// new one or takes its left neighbor's; on pop it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cmd_type   cmd,
   input  wire entry_type left_entry,
   input  wire logic      left_keep,
   input  wire entry_type right_entry,
   output entry_type      entry,
   output entry_type      entry_next,
   output logic           keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // The entry stays in place when it ranks at or above the new priority.
   assign keep = entry_ff.valid && (entry_ff.prio >= cmd.prio);

   // Next entry: shift right on insert below the kept part, shift left on pop.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (!keep) begin
            if (left_keep) begin
               entry_in.valid = 1'b1;
               entry_in.prio  = cmd.prio;
               entry_in.data  = cmd.data;
            end else begin
               entry_in = left_entry;
            end
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end
   end

   // Only the valid flag needs a reset.
   always_ff @(posedge clock) begin
      entry_ff.prio <= entry_in.prio;
      entry_ff.data <= entry_in.data;
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule
`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// One item is taken per cycle: a request transfer is answered by a response
// that is valid in the next cycle. A new request is accepted only while the
// response register is empty or its response transfers in that same cycle, so
// a stalled response receiver also stalls the requests. The speed is set by
// the row of cells, where every cell compares its priority with the inserted
// one and shifts in the same cycle. Equal priorities leave in arrival order;
// an insert into a full queue and a pop on an empty queue leave the contents
// unchanged and are reported in the status field.
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded max-first priority queue built as a row of sorting cells, with a
// registered response that carries the popped entry and a peek of the head.
// ----------------------------------------------------------------------------
module sorted_priority_queue
   import spq_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);

   localparam logic [COUNT_BITS-1:0] FULL_COUNT = COUNT_BITS'(CAPACITY);

   entry_type               cur_entry [CAPACITY];
   entry_type               nxt_entry [CAPACITY];
   logic [CAPACITY-1:0]     keep_vec;
   logic [CAPACITY-1:0]     valid_vec;
   cmd_type                 cmd;
   logic                    req_xfer;
   logic                    is_pop;
   logic                    is_full;
   logic                    is_emp;
   logic [COUNT_BITS-1:0]   count_ff;
   logic [COUNT_BITS-1:0]   count_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [1:0]              status_ff;
   logic [1:0]              status_in;
   logic                    popped_valid_ff;
   logic [DATA_BITS-1:0]    popped_data_ff;
   logic [DATA_BITS-1:0]    popped_data_in;
   logic [DATA_BITS-1:0]    head_data_ff;
   logic signed [PRIORITY_BITS-1:0] head_prio_ff;
   logic                    empty_ff;

   // A new request is taken whenever the response register is free or drains.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_xfer     = req_if.valid && req_if.ready;
   assign is_pop       = (req_if.opcode == OP_POP);
   assign is_full      = (count_ff == FULL_COUNT);
   assign is_emp       = (count_ff == '0);

   // Command for the row; rejected operations leave the cells alone.
   always_comb begin
      cmd.ins  = req_xfer && !is_pop && !is_full;
      cmd.pop  = req_xfer && is_pop && !is_emp;
      cmd.prio = req_if.priority_req;
      cmd.data = req_if.item_data;
   end

   // The row of cells; the head sits at index zero.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_k;

      if (i == 0) begin : g_head
         assign left_e = '0;
         assign left_k = 1'b1;
      end else begin : g_body
         assign left_e = cur_entry[i-1];
         assign left_k = keep_vec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = cur_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_e),
         .left_keep   (left_k),
         .right_entry (right_e),
         .entry       (cur_entry[i]),
         .entry_next  (nxt_entry[i]),
         .keep        (keep_vec[i])
      );

      assign valid_vec[i] = cur_entry[i].valid;
   end

   // Entry count and status of this transfer.
   always_comb begin
      count_in       = count_ff;
      status_in      = ST_OK;
      popped_data_in = '0;
      if (cmd.ins) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.pop) begin
         count_in       = count_ff - 1'b1;
         popped_data_in = cur_entry[0].data;
      end
      if (req_xfer && !is_pop && is_full) begin
         status_in = ST_FULL;
      end else if (req_xfer && is_pop && is_emp) begin
         status_in = ST_POP_EMPTY;
      end
   end

   // Response register is loaded on a request transfer and freed on drain.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload, with the head taken from the row's next state.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         status_ff       <= status_in;
         popped_valid_ff <= cmd.pop;
         popped_data_ff  <= popped_data_in;
         empty_ff        <= !nxt_entry[0].valid;
         head_data_ff    <= nxt_entry[0].valid ? nxt_entry[0].data : '0;
         head_prio_ff    <= nxt_entry[0].valid ? nxt_entry[0].prio : '0;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.status        = status_ff;
   assign rsp_if.popped_valid  = popped_valid_ff;
   assign rsp_if.popped_data   = popped_data_ff;
   assign rsp_if.head_data     = head_data_ff;
   assign rsp_if.head_priority = head_prio_ff;
   assign rsp_if.is_empty      = empty_ff;
   assign rsp_if.entry_count   = count_ff;

   // The valid cells always number exactly the entry count.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == 32'(count_ff))
      else $error("cell valid flags disagree with entry count");

   // Cells that rank at or above the new priority form an unbroken run from the head.
   a_keep_run: assert property (@(posedge clock) disable iff (reset)
      (keep_vec & (keep_vec + 1'b1)) == '0)
      else $error("row lost its sorted order");

   // An insert into a full queue leaves the count alone and flags it.
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !is_pop && is_full) |=>
         (count_ff == FULL_COUNT) && rsp_valid_ff && (status_ff == ST_FULL))
      else $error("insert into full queue was not dropped");

   // A pop on an empty queue reports the empty status and no data.
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && is_pop && is_emp) |=>
         (status_ff == ST_POP_EMPTY) && !popped_valid_ff && empty_ff)
      else $error("pop on empty queue misreported");

endmodule
`default_nettype wire
